// File: design/plc_pkg.sv
// Shared types and constants of the piecewise linear calibration unit.
`default_nettype none

package plc_pkg;

    localparam logic [1:0] FUNC_WR_FACTORY = 2'd0;
    localparam logic [1:0] FUNC_WR_USER    = 2'd1;
    localparam logic [1:0] FUNC_CONVERT    = 2'd2;

    localparam logic [2:0] REG_TABLE_SELECT   = 3'd0;
    localparam logic [2:0] REG_FACTORY_POINTS = 3'd1;
    localparam logic [2:0] REG_USER_POINTS    = 3'd2;
    localparam logic [2:0] REG_FACTORY_OFFSET = 3'd3;
    localparam logic [2:0] REG_USER_OFFSET    = 3'd4;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    typedef enum logic [1:0] {
        OP_WR_FACTORY,
        OP_WR_USER,
        OP_CONVERT
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [3:0]  slot;
        logic [15:0] reading;
        logic [15:0] ppress;
    } t_cmd;

    typedef struct packed {
        logic               sel;
        logic [3:0]         fpts;
        logic [3:0]         upts;
        logic signed [15:0] foff;
        logic signed [15:0] uoff;
    } t_cfg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LAST,
        S_FIRST,
        S_SCAN,
        S_FETCH,
        S_MUL,
        S_DSTART,
        S_DIV,
        S_SUM,
        S_FIN
    } t_state;

endpackage

`default_nettype wire

// File: design/plc_front.sv
// Front end: accepts input words, classifies them and drops those without effect.
`default_nettype none

module plc_front import plc_pkg::*; #(
    parameter int CAL_POINTS = 10
) (
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_func,
    input  wire logic [3:0]  i_point_index,
    input  wire logic [15:0] i_reading,
    input  wire logic [15:0] i_point_pressure,
    input  wire logic        i_full,
    output logic             o_push,
    output t_cmd             o_cmd
);

    logic w_keep;
    logic w_slot_ok;

    assign w_slot_ok  = int'(i_point_index) < CAL_POINTS;
    assign o_in_ready = !i_full;

    always_comb begin
        o_cmd.slot    = i_point_index;
        o_cmd.reading = i_reading;
        o_cmd.ppress  = i_point_pressure;
        o_cmd.op      = OP_CONVERT;
        w_keep        = 1'b0;
        case (i_func)
            FUNC_WR_FACTORY: begin
                o_cmd.op = OP_WR_FACTORY;
                w_keep   = w_slot_ok;
            end
            FUNC_WR_USER: begin
                o_cmd.op = OP_WR_USER;
                w_keep   = w_slot_ok;
            end
            FUNC_CONVERT: begin
                o_cmd.op = OP_CONVERT;
                w_keep   = 1'b1;
            end
            default: begin
                w_keep = 1'b0;
            end
        endcase
    end

    assign o_push = i_in_valid && !i_full && w_keep;

endmodule

`default_nettype wire

// File: design/plc_fifo.sv
// Short command queue between the front end and the conversion engine.
`default_nettype none

module plc_fifo import plc_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_cmd      i_cmd,
    output logic      o_full,
    input  wire logic i_pop,
    output t_cmd      o_cmd,
    output logic      o_empty
);

    t_cmd                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;

    assign o_full  = r_count == (QUEUE_AW+1)'(QUEUE_DEPTH);
    assign o_empty = r_count == '0;
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QUEUE_AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QUEUE_AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (QUEUE_AW+1)'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - (QUEUE_AW+1)'(1);
            end
        end
    end

endmodule

`default_nettype wire

// File: design/plc_div.sv
// Restoring divider of a 32-bit magnitude by a 16-bit magnitude, one quotient bit a cycle.
`default_nettype none

module plc_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_dividend,
    input  wire logic [15:0] i_divisor,
    output logic             o_done,
    output logic [31:0]      o_quot
);

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [15:0] r_rem;
    logic [31:0] r_q;
    logic [15:0] r_den;
    logic [16:0] w_trial;
    logic [16:0] w_diff;
    logic        w_ge;

    assign w_trial = {r_rem, r_q[31]};
    assign w_ge    = w_trial >= {1'b0, r_den};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign o_done  = r_done;
    assign o_quot  = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_q   <= i_dividend;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[15:0] : w_trial[15:0];
            r_q   <= {r_q[30:0], w_ge};
        end
    end

endmodule

`default_nettype wire

// File: design/plc_back.sv
// Conversion engine: table memories, segment search, interpolation and result register.
`default_nettype none

module plc_back import plc_pkg::*; #(
    parameter int CAL_POINTS = 10
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  t_cfg        i_cfg,
    input  wire logic   i_empty,
    input  t_cmd        i_cmd,
    output logic        o_pop,
    output logic        o_out_valid,
    input  wire logic   i_out_ready,
    output logic [14:0] o_pressure,
    output logic        o_zero_span
);

    localparam int IW = $clog2(CAL_POINTS);
    localparam int CW = $clog2(CAL_POINTS + 1);

    logic [31:0] r_mem_f [CAL_POINTS];
    logic [31:0] r_mem_u [CAL_POINTS];
    logic [31:0] r_rd_f;
    logic [31:0] r_rd_u;

    t_state             r_state;
    t_state             n_state;
    logic               r_use_user;
    logic [CW-1:0]      r_n;
    logic [IW-1:0]      r_idx;
    logic               r_last_gt;
    logic [15:0]        r_reading;
    logic signed [16:0] r_off;
    logic [15:0]        r_xb;
    logic [15:0]        r_yb;
    logic [15:0]        r_ya;
    logic signed [16:0] r_dx;
    logic signed [16:0] r_dr;
    logic signed [16:0] r_dy;
    logic signed [33:0] r_prod;
    logic               r_neg;
    logic signed [35:0] r_val;
    logic               r_zs;
    logic               r_out_valid;
    logic [14:0]        r_out_press;
    logic               r_out_zs;

    logic [CW-1:0]      w_nf;
    logic [CW-1:0]      w_nu;
    logic               w_use_user;
    logic [CW-1:0]      w_n;
    logic               w_trivial;
    logic signed [16:0] w_off;
    logic [31:0]        w_rd;
    logic [15:0]        w_x;
    logic [15:0]        w_y;
    logic               w_found;
    logic               w_below;
    logic               w_dx_zero;
    logic               w_pop;
    logic               w_conv;
    logic [IW-1:0]      w_rd_addr;
    logic               w_div_start;
    logic               w_div_done;
    logic [31:0]        w_div_q;
    logic [31:0]        w_dividend;
    logic [15:0]        w_divisor;
    logic [35:0]        w_q;
    logic [35:0]        w_qs;
    logic [14:0]        w_press;
    logic               w_load;

    assign w_nf = (int'(i_cfg.fpts) > CAL_POINTS) ? CW'(CAL_POINTS) : CW'(i_cfg.fpts);
    assign w_nu = (int'(i_cfg.upts) > CAL_POINTS) ? CW'(CAL_POINTS) : CW'(i_cfg.upts);
    assign w_use_user = i_cfg.sel && (w_nu > CW'(1));
    assign w_n        = w_use_user ? w_nu : w_nf;
    assign w_trivial  = !w_use_user && (w_nf < CW'(2));

    always_comb begin
        if (w_use_user) begin
            w_off = 17'(i_cfg.uoff);
        end else if (i_cfg.sel && (w_nu == CW'(1))) begin
            w_off = 17'(i_cfg.foff) + 17'(i_cfg.uoff);
        end else begin
            w_off = 17'(i_cfg.foff);
        end
    end

    assign w_rd      = r_use_user ? r_rd_u : r_rd_f;
    assign w_x       = w_rd[31:16];
    assign w_y       = w_rd[15:0];
    assign w_found   = (r_reading < w_x) || (CW'(r_idx) == r_n - CW'(1));
    assign w_below   = !r_use_user && (r_reading < w_x);
    assign w_dx_zero = r_xb == w_x;
    assign w_conv    = i_cmd.op == OP_CONVERT;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (!i_empty && w_conv) begin
                    n_state = w_trivial ? S_FIN : S_LAST;
                end
            end
            S_LAST: begin
                n_state = S_FIRST;
            end
            S_FIRST: begin
                n_state = w_below ? S_FIN : S_SCAN;
            end
            S_SCAN: begin
                if (w_found) begin
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                n_state = w_dx_zero ? S_FIN : S_MUL;
            end
            S_MUL: begin
                n_state = S_DSTART;
            end
            S_DSTART: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        w_pop       = 1'b0;
        w_div_start = 1'b0;
        w_load      = 1'b0;
        w_rd_addr   = r_idx;
        case (r_state)
            S_IDLE: begin
                w_pop     = !i_empty;
                w_rd_addr = IW'(w_n - CW'(1));
            end
            S_LAST: begin
                w_rd_addr = '0;
            end
            S_FIRST: begin
                w_rd_addr = r_last_gt ? IW'(r_n - CW'(1)) : IW'(1);
            end
            S_SCAN: begin
                w_rd_addr = w_found ? (r_idx - IW'(1)) : (r_idx + IW'(1));
            end
            S_DSTART: begin
                w_div_start = 1'b1;
            end
            S_FIN: begin
                w_load = !r_out_valid || i_out_ready;
            end
            default: begin
                w_rd_addr = r_idx;
            end
        endcase
    end

    assign o_pop = w_pop;

    always_ff @(posedge i_clk) begin
        if (w_pop && (i_cmd.op == OP_WR_FACTORY)) begin
            r_mem_f[IW'(i_cmd.slot)] <= {i_cmd.reading, i_cmd.ppress};
        end
        if (w_pop && (i_cmd.op == OP_WR_USER)) begin
            r_mem_u[IW'(i_cmd.slot)] <= {i_cmd.reading, i_cmd.ppress};
        end
        r_rd_f <= r_mem_f[w_rd_addr];
        r_rd_u <= r_mem_u[w_rd_addr];
    end

    assign w_dividend = r_prod[33] ? 32'(-r_prod) : 32'(r_prod);
    assign w_divisor  = r_dx[16] ? 16'(-r_dx) : 16'(r_dx);

    plc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quot     (w_div_q)
    );

    assign w_q  = {4'b0, w_div_q};
    assign w_qs = r_neg ? (36'd0 - w_q) : w_q;

    always_comb begin
        if (r_val[35]) begin
            w_press = '0;
        end else if (r_val > 36'sd32767) begin
            w_press = 15'h7fff;
        end else begin
            w_press = r_val[14:0];
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_use_user <= w_use_user;
                r_n        <= w_n;
                r_reading  <= i_cmd.reading;
                r_off      <= w_off;
                r_val      <= '0;
                r_zs       <= 1'b0;
            end
            S_LAST: begin
                r_last_gt <= r_reading > w_x;
            end
            S_FIRST: begin
                r_idx <= r_last_gt ? IW'(r_n - CW'(1)) : IW'(1);
            end
            S_SCAN: begin
                r_xb <= w_x;
                r_yb <= w_y;
                if (!w_found) begin
                    r_idx <= r_idx + IW'(1);
                end
            end
            S_FETCH: begin
                r_ya <= w_y;
                r_dx <= $signed({1'b0, r_xb}) - $signed({1'b0, w_x});
                r_dr <= $signed({1'b0, r_reading}) - $signed({1'b0, w_x});
                r_dy <= $signed({1'b0, r_yb}) - $signed({1'b0, w_y});
                r_zs <= w_dx_zero;
            end
            S_MUL: begin
                r_prod <= r_dr * r_dy;
            end
            S_DSTART: begin
                r_neg <= r_prod[33] ^ r_dx[16];
            end
            S_SUM: begin
                r_val <= $signed(36'({1'b0, r_ya}) + w_qs + 36'(r_off));
            end
            default: begin
                r_zs <= r_zs;
            end
        endcase
        if (w_load) begin
            r_out_press <= w_press;
            r_out_zs    <= r_zs;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_pressure  = r_out_press;
    assign o_zero_span = r_out_zs;

`ifndef SYNTHESIS
    a_div_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV))
        else $error("Divider finished outside its wait state.");

    a_zero_span_gives_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_zs) |-> (r_out_press == 15'd0))
        else $error("Zero span result carries a non-zero pressure.");

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> r_out_valid)
        else $error("Loaded result word is not shown as valid.");

    a_scan_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (CW'(r_idx) < r_n))
        else $error("Segment search left the populated table.");
`endif

endmodule

`default_nettype wire

// File: design/piecewise_linear_calibration_unit.sv
// Top level of the piecewise linear calibration unit with its register file.
// A conversion runs the segment search over the table, then the 32-step serial divider; the
// search length depends on where the reading falls in the table.
// The engine handles one command at a time while the queue holds up to four more; a reading
// below the factory table or a factory table of fewer than two points skips the interpolation.
// Reset clears the registers, queue and control; the table contents stay undefined.
`default_nettype none

module piecewise_linear_calibration_unit import plc_pkg::*; #(
    parameter int CAL_POINTS = 10
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_func,
    input  wire logic [3:0]  i_point_index,
    input  wire logic [15:0] i_reading,
    input  wire logic [15:0] i_point_pressure,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [14:0]      o_pressure,
    output logic             o_zero_span,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    t_cfg       r_cfg;
    logic       w_wr;
    logic [2:0] w_reg;
    logic       w_push;
    logic       w_full;
    logic       w_pop;
    logic       w_empty;
    t_cmd       w_push_cmd;
    t_cmd       w_head_cmd;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_reg  = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (w_wr) begin
            case (w_reg)
                REG_TABLE_SELECT:   r_cfg.sel  <= pwdata[0];
                REG_FACTORY_POINTS: r_cfg.fpts <= pwdata[3:0];
                REG_USER_POINTS:    r_cfg.upts <= pwdata[3:0];
                REG_FACTORY_OFFSET: r_cfg.foff <= pwdata[15:0];
                REG_USER_OFFSET:    r_cfg.uoff <= pwdata[15:0];
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    always_comb begin
        case (w_reg)
            REG_TABLE_SELECT:   prdata = {31'b0, r_cfg.sel};
            REG_FACTORY_POINTS: prdata = {28'b0, r_cfg.fpts};
            REG_USER_POINTS:    prdata = {28'b0, r_cfg.upts};
            REG_FACTORY_OFFSET: prdata = 32'(r_cfg.foff);
            REG_USER_OFFSET:    prdata = 32'(r_cfg.uoff);
            default:            prdata = '0;
        endcase
    end

    plc_front #(
        .CAL_POINTS (CAL_POINTS)
    ) u_front (
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_func           (i_func),
        .i_point_index    (i_point_index),
        .i_reading        (i_reading),
        .i_point_pressure (i_point_pressure),
        .i_full           (w_full),
        .o_push           (w_push),
        .o_cmd            (w_push_cmd)
    );

    plc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_cmd   (w_head_cmd),
        .o_empty (w_empty)
    );

    plc_back #(
        .CAL_POINTS (CAL_POINTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_empty     (w_empty),
        .i_cmd       (w_head_cmd),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_pressure  (o_pressure),
        .o_zero_span (o_zero_span)
    );

endmodule

`default_nettype wire
